@@ hdl/combined_lfsr_byte_masker_macros.svh @@
// Assertion macros for the combined LFSR byte masker.
// Each macro expands to one labeled concurrent assertion on clk and rst_n.
`ifndef COMBINED_LFSR_BYTE_MASKER_MACROS_SVH
`define COMBINED_LFSR_BYTE_MASKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLLBM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CLLBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/cllbm_pkg.sv @@
// Shared constants, types and the LFSR step function of the combined LFSR byte masker.
// No dependencies; the interfaces and modules of the block refer to it by scoped names.
package cllbm_pkg;

  localparam int DATA_W        = 8;
  localparam int BITS_PER_ITEM = 8;
  localparam int KS_ACC_W      = 32;

  localparam int SHORT_LEN = 19;
  localparam int SHORT_TAP = 6;
  localparam int LONG_LEN  = 118;
  localparam int LONG_TAP  = 84;

  localparam logic [SHORT_LEN-1:0] SHORT_SEED = 19'h43E8B;
  localparam logic [LONG_LEN-1:0]  LONG_SEED  =
    118'b1111111001110010011000011001010100010010000101111111110101001010000000110001101111111011111011110010010000101111001101;

  typedef logic [DATA_W-1:0] byte_t;

  typedef struct packed {
    logic [SHORT_LEN-1:0] sr;
    logic [LONG_LEN-1:0]  lr;
  } lfsr_state_t;

  typedef struct packed {
    lfsr_state_t state;
    byte_t       ks;
  } lfsr_adv_t;

  // Steps both registers BITS_PER_ITEM times; the first keystream bit lands
  // furthest left, and the low DATA_W bits form the mask.
  function automatic lfsr_adv_t lfsr_advance(lfsr_state_t cur);
    lfsr_state_t         s;
    logic [KS_ACC_W-1:0] acc;
    logic                fb1;
    logic                fb2;
    lfsr_adv_t           res;
    s   = cur;
    acc = '0;
    for (int i = 0; i < BITS_PER_ITEM; i++) begin
      fb1  = s.sr[0] ^ s.sr[SHORT_TAP];
      fb2  = s.lr[LONG_LEN-1] ^ s.lr[LONG_TAP];
      s.sr = {fb1, s.sr[SHORT_LEN-1:1]};
      s.lr = {fb2, s.lr[LONG_LEN-1:1]};
      acc  = {acc[KS_ACC_W-2:0], fb1 ^ fb2};
    end
    res.state = s;
    res.ks    = acc[DATA_W-1:0];
    return res;
  endfunction

endpackage

@@ hdl/cllbm_in_if.sv @@
// Input channel of the combined LFSR byte masker: valid, ready and one data byte.
// Depends on cllbm_pkg for the byte type.
interface cllbm_in_if;
  logic               valid;
  logic               ready;
  cllbm_pkg::byte_t   data_in;

  modport source (output valid, output data_in, input ready);
  modport sink   (input valid, input data_in, output ready);
endinterface

@@ hdl/cllbm_out_if.sv @@
// Result channel of the combined LFSR byte masker: valid, ready and one masked byte.
// Depends on cllbm_pkg for the byte type.
interface cllbm_out_if;
  logic               valid;
  logic               ready;
  cllbm_pkg::byte_t   data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

@@ hdl/cllbm_keystream.sv @@
// Keystream generator: the 19-bit and 118-bit LFSR state and its per-beat advance.
// Depends on cllbm_pkg for the seeds and the step function.
module cllbm_keystream (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  output cllbm_pkg::byte_t ks_byte
);

  cllbm_pkg::lfsr_state_t state_r;
  cllbm_pkg::lfsr_state_t state_nxt;
  cllbm_pkg::lfsr_adv_t   adv;

  always_comb begin
    adv       = cllbm_pkg::lfsr_advance(state_r);
    state_nxt = advance ? adv.state : state_r;
  end

  assign ks_byte = adv.ks;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.sr <= cllbm_pkg::SHORT_SEED;
      state_r.lr <= cllbm_pkg::LONG_SEED;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/cllbm_out_stage.sv @@
// Result register: holds one masked byte until the sink takes it.
// Depends on cllbm_pkg and the cllbm_out_if interface.
module cllbm_out_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  cllbm_pkg::byte_t   load_data,
  output logic               space,
  cllbm_out_if.source        out_ch
);

  logic             valid_r;
  logic             valid_nxt;
  cllbm_pkg::byte_t data_r;
  cllbm_pkg::byte_t data_nxt;

  // Room for a new beat when empty or when the held beat leaves this cycle.
  assign space = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = load_data;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_ch.valid    = valid_r;
  assign out_ch.data_out = data_r;

endmodule

@@ hdl/combined_lfsr_byte_masker.sv @@
// Combined LFSR byte masker, top level: XORs each data byte with 8 keystream bits.
// An accepted input beat's result is registered and appears on the output in the next cycle.
// Throughput: 1 beat per cycle while the sink keeps up; the keystream advance is 8 unrolled LFSR steps in XOR logic.
// Reset: synchronous active-low rst_n loads both LFSR seeds and empties the result register.
// Depends on cllbm_pkg, cllbm_in_if, cllbm_out_if, cllbm_keystream and cllbm_out_stage.
`include "combined_lfsr_byte_masker_macros.svh"

module combined_lfsr_byte_masker (
  input  logic        clk,
  input  logic        rst_n,
  cllbm_in_if.sink    in_ch,
  cllbm_out_if.source out_ch
);

  // The keystream byte for the next beat is always waiting as combinational
  // logic on the current LFSR state. When a beat is accepted, the masked byte
  // is captured in the result register and both LFSRs step eight times in the
  // same edge, so the next beat sees fresh keystream without a bubble.
  logic             in_accept;
  logic             out_space;
  cllbm_pkg::byte_t ks_byte;
  cllbm_pkg::byte_t masked;

  // Input is taken whenever the result register is empty or is being drained
  // this cycle, so a result that leaves in this cycle never blocks the next
  // beat from entering. A result that the sink refuses holds the input off.
  assign in_ch.ready = out_space;
  assign in_accept   = in_ch.valid && out_space;

  // Masking and unmasking are the same XOR.
  assign masked = in_ch.data_in ^ ks_byte;

  cllbm_keystream u_keystream (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_accept),
    .ks_byte (ks_byte)
  );

  cllbm_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept),
    .load_data (masked),
    .space     (out_space),
    .out_ch    (out_ch)
  );

  // Every accepted beat shows up as a result in the following cycle.
  `CLLBM_ASSERT_NEXT(a_accept_gives_result, in_accept, out_ch.valid, "accepted beat has no result")

  // The result carries the input byte masked with the keystream seen at accept.
  `CLLBM_ASSERT_NEXT(a_result_value, in_accept, out_ch.data_out == $past(masked), "wrong masked byte")

  // The keystream only moves when a beat is accepted.
  `CLLBM_ASSERT_NEXT(a_ks_holds, !in_accept, $stable(ks_byte), "keystream advanced without a beat")

  // An empty result register always leaves the input open.
  `CLLBM_ASSERT_NOW(a_empty_ready, !out_ch.valid, in_ch.ready, "input blocked while result empty")

endmodule
